// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the periodic cubic interpolator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// the expression must never hold while out of reset
`define CHK_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");

// when the antecedent holds, the consequent holds in the next cycle
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CHK_NEVER(lbl, clk, rstn, expr)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/pci_pkg.sv =====
// ----------------------------------------------------------------------------
// pci_pkg
// Shared constants, datapath operation codes and control/status structs
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int MAX_CELLS      = 64;
    localparam int MIN_CELLS      = 3;
    localparam int SUPPORT_POINTS = 4;
    localparam int SP_W           = $clog2(SUPPORT_POINTS);
    localparam int ADDR_W         = $clog2(MAX_CELLS + 1);
    localparam int CELL_W         = $clog2(MAX_CELLS);
    localparam int CFG_W          = 7;
    localparam int INDEX_W        = 7;
    localparam int DATA_W         = 32;
    localparam int WFRAC          = 28;
    localparam int DIV_W          = 35;
    localparam int DVD_W          = 64;

    // item operation codes
    localparam logic OPER_WRITE = 1'b0;
    localparam logic OPER_EVAL  = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_RD_X0,
        OP_RD_XN,
        OP_RD_SCAN,
        OP_RD_SUP,
        OP_SET_X0,
        OP_MOD_PREP,
        OP_DIV_MOD,
        OP_MOD_FIN,
        OP_CELL,
        OP_W_INIT,
        OP_F_PREP,
        OP_DIV_FAC,
        OP_F_ZERO,
        OP_F_SAT,
        OP_MUL_WF,
        OP_W_UPD,
        OP_MUL_WY,
        OP_ACC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ADDR_W-1:0] idx;
        logic [SP_W-1:0]   i;
        logic [SP_W-1:0]   j;
    } dp_cmd_t;

    typedef struct packed {
        logic              need_wrap;
        logic              d_pos;
        logic              den_zero;
        logic              div_busy;
        logic [ADDR_W-1:0] n_eff;
    } dp_stat_t;

endpackage

// ===== rtl/pci_if.sv =====
// ----------------------------------------------------------------------------
// pci_if
// Valid/ready channel interfaces of the periodic cubic interpolator
// ----------------------------------------------------------------------------
interface pci_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic        [pci_pkg::INDEX_W-1:0]  node_index;
    logic signed [pci_pkg::DATA_W-1:0]   node_position;
    logic signed [pci_pkg::DATA_W-1:0]   node_value;
    logic signed [pci_pkg::DATA_W-1:0]   eval_position;

    modport source (output valid, operation, node_index, node_position, node_value,
                    eval_position, input ready);
    modport sink   (input valid, operation, node_index, node_position, node_value,
                    eval_position, output ready);
endinterface

interface pci_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [pci_pkg::DATA_W-1:0] interp_value;
    logic                              period_mismatch;

    modport source (output valid, interp_value, period_mismatch, input ready);
    modport sink   (input valid, interp_value, period_mismatch, output ready);
endinterface

interface pci_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pci_pkg::CFG_W-1:0]    region_count;

    modport source (output valid, region_count, input ready);
    modport sink   (input valid, region_count, output ready);
endinterface

// ===== rtl/periodic_cubic_interp.sv =====
// ----------------------------------------------------------------------------
// periodic_cubic_interp
// Cubic Lagrange interpolation on a periodic nonuniform grid, signed Q16.16
//
//   channel   dir   payload
//   item      in    operation, node_index, node_position, node_value,
//                   eval_position
//   result    out   interp_value, period_mismatch
//   cfg       in    region_count (always ready)
//
// A write transaction is taken in the idle state, which the sequencer does not leave,
// so item stays ready. An evaluate transaction holds item ready low until its result
// is loaded. The divider computes the wrap, when the position must be wrapped and the
// period is positive, and all twelve Lagrange factors but those with a zero denominator,
// which are set to zero. Reset loads region_count with 64; the node table is not cleared.
// A finished result waits in the output register while the next transaction is taken;
// a new result waits only if that register is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_cubic_interp (
    input  logic          clk,
    input  logic          rst_n,
    pci_item_if.sink      item,
    pci_result_if.source  result,
    pci_cfg_if.sink       cfg
);
    import pci_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    // sequencer
    pci_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_operation (item.operation),
        .item_ready     (item.ready),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    // table and arithmetic
    pci_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.region_count),
        .item_operation  (item.operation),
        .node_index      (item.node_index),
        .node_position   (item.node_position),
        .node_value      (item.node_value),
        .eval_position   (item.eval_position),
        .interp_value    (result.interp_value),
        .period_mismatch (result.period_mismatch)
    );

    // checks
    `CHK_NEXT(a_eval_busy, clk, rst_n, item.valid && item.ready && (item.operation == OPER_EVAL), !item.ready)
    `CHK_NEVER(a_div_idle, clk, rst_n, item.ready && stat.div_busy)
    `CHK_NEVER(a_n_range, clk, rst_n, (stat.n_eff < ADDR_W'(MIN_CELLS)) || (stat.n_eff > ADDR_W'(MAX_CELLS)))
    `CHK_NEXT(a_out_load, clk, rst_n, cmd.op == OP_OUT, result.valid)

endmodule

// ===== rtl/pci_div.sv =====
// ----------------------------------------------------------------------------
// pci_div
// Restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pci_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pci_pkg::DVD_W-1:0]   dividend,
    input  logic [pci_pkg::DIV_W-1:0]   divisor,
    output logic [pci_pkg::DVD_W-1:0]   quotient,
    output logic [pci_pkg::DIV_W-1:0]   remainder,
    output logic                        busy
);
    import pci_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg,  quo_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[DIV_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
    end

    // step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
                busy_reg <= 1'b0;
        end
    end

    // quotient and remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

// ===== rtl/pci_ctrl.sv =====
// ----------------------------------------------------------------------------
// pci_ctrl
// Sequencer: issues datapath operations for table writes and evaluations
// ----------------------------------------------------------------------------
module pci_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_operation,
    output logic               item_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pci_pkg::dp_stat_t  stat,
    output pci_pkg::dp_cmd_t   cmd
);
    import pci_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_X0,
        S_RD_XN,
        S_LAND,
        S_WRAP,
        S_MOD_DIV,
        S_MOD_WAIT,
        S_MOD_FIN,
        S_SCAN,
        S_SCAN_W,
        S_CELL,
        S_SUP,
        S_SUP_W,
        S_W_INIT,
        S_F_PREP,
        S_F_CHK,
        S_F_WAIT,
        S_MUL_WF,
        S_W_UPD,
        S_MUL_WY,
        S_ACC,
        S_OUT
    } state_t;

    state_t            state_reg,     state_next;
    logic [ADDR_W-1:0] cnt_reg,       cnt_next;
    logic [SP_W-1:0]   i_reg,         i_next;
    logic [SP_W-1:0]   j_reg,         j_next;
    logic              out_valid_reg, out_valid_next;
    logic [SP_W:0]     j_inc;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NOP;
        cmd.idx        = cnt_reg;
        cmd.i          = i_reg;
        cmd.j          = j_reg;

        // next factor index, skipping the weight's own node
        j_inc = {1'b0, j_reg} + (SP_W + 1)'(1);
        if (!j_inc[SP_W] && (j_inc[SP_W-1:0] == i_reg))
            j_inc = j_inc + (SP_W + 1)'(1);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op = OP_CAPTURE;
                    if (item_operation == OPER_EVAL)
                        state_next = S_RD_X0;
                end
            end
            S_RD_X0:
            begin
                cmd.op     = OP_RD_X0;
                state_next = S_RD_XN;
            end
            S_RD_XN:
            begin
                cmd.op     = OP_RD_XN;
                state_next = S_LAND;
            end
            S_LAND:
                state_next = S_WRAP;
            S_WRAP:
            begin
                cnt_next = '0;
                if (!stat.need_wrap)
                    state_next = S_SCAN;
                else if (!stat.d_pos)
                begin
                    cmd.op     = OP_SET_X0;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.op     = OP_MOD_PREP;
                    state_next = S_MOD_DIV;
                end
            end
            S_MOD_DIV:
            begin
                cmd.op     = OP_DIV_MOD;
                state_next = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_MOD_FIN;
            end
            S_MOD_FIN:
            begin
                cmd.op     = OP_MOD_FIN;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_RD_SCAN;
                if (cnt_reg == stat.n_eff)
                    state_next = S_SCAN_W;
                else
                    cnt_next = cnt_reg + ADDR_W'(1);
            end
            S_SCAN_W:
                state_next = S_CELL;
            S_CELL:
            begin
                cmd.op     = OP_CELL;
                i_next     = '0;
                state_next = S_SUP;
            end
            S_SUP:
            begin
                cmd.op = OP_RD_SUP;
                if (i_reg == SP_W'(SUPPORT_POINTS - 1))
                begin
                    i_next     = '0;
                    state_next = S_SUP_W;
                end
                else
                    i_next = i_reg + SP_W'(1);
            end
            S_SUP_W:
                state_next = S_W_INIT;
            S_W_INIT:
            begin
                cmd.op     = OP_W_INIT;
                j_next     = (i_reg == '0) ? SP_W'(1) : '0;
                state_next = S_F_PREP;
            end
            S_F_PREP:
            begin
                cmd.op     = OP_F_PREP;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (stat.den_zero)
                begin
                    cmd.op     = OP_F_ZERO;
                    state_next = S_MUL_WF;
                end
                else
                begin
                    cmd.op     = OP_DIV_FAC;
                    state_next = S_F_WAIT;
                end
            end
            S_F_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = OP_F_SAT;
                    state_next = S_MUL_WF;
                end
            end
            S_MUL_WF:
            begin
                cmd.op     = OP_MUL_WF;
                state_next = S_W_UPD;
            end
            S_W_UPD:
            begin
                cmd.op = OP_W_UPD;
                if (j_inc[SP_W])
                    state_next = S_MUL_WY;
                else
                begin
                    j_next     = j_inc[SP_W-1:0];
                    state_next = S_F_PREP;
                end
            end
            S_MUL_WY:
            begin
                cmd.op     = OP_MUL_WY;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (i_reg == SP_W'(SUPPORT_POINTS - 1))
                    state_next = S_OUT;
                else
                begin
                    i_next     = i_reg + SP_W'(1);
                    state_next = S_W_INIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;

endmodule

// ===== rtl/pci_dpath.sv =====
// ----------------------------------------------------------------------------
// pci_dpath
// Node table, period wrap, cell search, support gather and Lagrange weights
// ----------------------------------------------------------------------------
module pci_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pci_pkg::dp_cmd_t                    cmd,
    output pci_pkg::dp_stat_t                   stat,
    input  logic                                cfg_we,
    input  logic        [pci_pkg::CFG_W-1:0]    cfg_data,
    input  logic                                item_operation,
    input  logic        [pci_pkg::INDEX_W-1:0]  node_index,
    input  logic signed [pci_pkg::DATA_W-1:0]   node_position,
    input  logic signed [pci_pkg::DATA_W-1:0]   node_value,
    input  logic signed [pci_pkg::DATA_W-1:0]   eval_position,
    output logic signed [pci_pkg::DATA_W-1:0]   interp_value,
    output logic                                period_mismatch
);
    import pci_pkg::*;

    localparam int XS_W  = DATA_W + 2;
    localparam int SUM_W = DATA_W + 6;
    localparam int PRD_W = 2 * DATA_W;
    localparam int MRD_W = PRD_W - WFRAC;
    localparam logic [DATA_W-1:0] WCAP  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] WONE  = DATA_W'(1) << WFRAC;
    localparam logic [PRD_W-1:0]  WHALF = PRD_W'(1) << (WFRAC - 1);

    typedef enum logic [1:0] {ADJ_NONE, ADJ_MINUS, ADJ_PLUS} adj_t;

    // node table
    logic signed [DATA_W-1:0] pos_mem [0:MAX_CELLS];
    logic signed [DATA_W-1:0] val_mem [0:MAX_CELLS];

    logic [CFG_W-1:0]         region_count_reg;
    logic [ADDR_W-1:0]        n_eff;
    logic [ADDR_W-1:0]        last_cell;
    logic                     mem_we;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    adj_t                     rd_adj;
    logic [ADDR_W-1:0]        sup_sum;

    logic signed [DATA_W-1:0] rd_pos_reg;
    logic signed [DATA_W-1:0] rd_val_reg;
    dp_op_t                   rd_op_reg;
    logic [SP_W-1:0]          rd_k_reg;
    adj_t                     rd_adj_reg;

    logic signed [DATA_W-1:0] x_reg, x0_reg, x1_reg, y0_reg, yn_reg;
    logic signed [DATA_W:0]   period;
    logic [ADDR_W-1:0]        below_reg;
    logic [ADDR_W-1:0]        below_m1;
    logic [CELL_W-1:0]        cell_reg;
    logic signed [XS_W-1:0]   xs_reg [0:SUPPORT_POINTS-1];
    logic signed [DATA_W-1:0] ys_reg [0:SUPPORT_POINTS-1];
    logic signed [XS_W-1:0]   xi_reg;
    logic signed [DATA_W-1:0] yi_reg;
    logic signed [DIV_W-1:0]  num_reg, den_reg;
    logic [DIV_W-1:0]         num_mag, den_mag;
    logic [DIV_W-1:0]         mod_r;
    logic [DATA_W-1:0]        w_mag_reg, f_mag_reg, yi_mag;
    logic                     w_neg_reg, f_neg_reg;
    logic [PRD_W-1:0]         prod_reg, prod_rnd;
    logic                     prod_neg_reg;
    logic [MRD_W-1:0]         prod_m;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] interp_reg;
    logic                     mismatch_reg;

    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVD_W-1:0]         div_quo;
    logic [DIV_W-1:0]         div_rem;
    logic                     div_busy;

    // effective cell count
    always_comb
    begin
        if (region_count_reg < CFG_W'(MIN_CELLS))
            n_eff = ADDR_W'(MIN_CELLS);
        else if (region_count_reg > CFG_W'(MAX_CELLS))
            n_eff = ADDR_W'(MAX_CELLS);
        else
            n_eff = ADDR_W'(region_count_reg);
    end
    assign last_cell = n_eff - ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_count_reg <= CFG_W'(MAX_CELLS);
        else if (cfg_we)
            region_count_reg <= cfg_data;
    end

    // table read address and period adjustment of support nodes
    assign sup_sum = ADDR_W'(cell_reg) + ADDR_W'(cmd.i) - ADDR_W'(1);
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        rd_adj  = ADJ_NONE;
        unique case (cmd.op)
            OP_RD_X0:   rd_addr = '0;
            OP_RD_XN:   rd_addr = n_eff;
            OP_RD_SCAN: rd_addr = cmd.idx;
            OP_RD_SUP:
            begin
                if ((cell_reg == '0) && (cmd.i == '0))
                begin
                    rd_addr = last_cell;
                    rd_adj  = ADJ_MINUS;
                end
                else if ((ADDR_W'(cell_reg) == last_cell) &&
                         (cmd.i == SP_W'(SUPPORT_POINTS - 1)))
                begin
                    rd_addr = ADDR_W'(1);
                    rd_adj  = ADJ_PLUS;
                end
                else
                    rd_addr = sup_sum;
            end
            default:    rd_en = 1'b0;
        endcase
    end

    assign mem_we = (cmd.op == OP_CAPTURE) && (item_operation == OPER_WRITE) &&
                    (node_index <= INDEX_W'(MAX_CELLS));

    // table memories, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[node_index[ADDR_W-1:0]] <= node_position;
            val_mem[node_index[ADDR_W-1:0]] <= node_value;
        end
        if (rd_en)
        begin
            rd_pos_reg <= pos_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // read tag, registered alongside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_op_reg  <= OP_NOP;
            rd_k_reg   <= '0;
            rd_adj_reg <= ADJ_NONE;
        end
        else
        begin
            rd_op_reg  <= rd_en ? cmd.op : OP_NOP;
            rd_k_reg   <= cmd.i;
            rd_adj_reg <= rd_adj;
        end
    end

    // shared divider operands
    assign period    = (DATA_W + 1)'(x1_reg) - (DATA_W + 1)'(x0_reg);
    assign num_mag   = num_reg[DIV_W-1] ? DIV_W'(-num_reg) : DIV_W'(num_reg);
    assign den_mag   = den_reg[DIV_W-1] ? DIV_W'(-den_reg) : DIV_W'(den_reg);
    assign div_start = (cmd.op == OP_DIV_MOD) || (cmd.op == OP_DIV_FAC);
    assign div_dvd   = (cmd.op == OP_DIV_MOD) ? DVD_W'(num_mag) :
                       ((DVD_W'(num_mag) << WFRAC) + DVD_W'(den_mag >> 1));

    pci_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (den_mag),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy)
    );

    // rounding of products back to q.28 and misc helpers
    assign prod_rnd = prod_reg + WHALF;
    assign prod_m   = prod_rnd[PRD_W-1:WFRAC];
    assign yi_mag   = yi_reg[DATA_W-1] ? DATA_W'(-yi_reg) : DATA_W'(yi_reg);
    assign mod_r    = (num_reg[DIV_W-1] && (div_rem != '0)) ? (den_mag - div_rem) : div_rem;
    assign below_m1 = below_reg - ADDR_W'(1);

    // datapath registers
    always_ff @(posedge clk)
    begin
        // landing of table reads
        unique case (rd_op_reg)
            OP_RD_X0:
            begin
                x0_reg <= rd_pos_reg;
                y0_reg <= rd_val_reg;
            end
            OP_RD_XN:
            begin
                x1_reg <= rd_pos_reg;
                yn_reg <= rd_val_reg;
            end
            OP_RD_SCAN:
            begin
                if (rd_pos_reg < x_reg)
                    below_reg <= below_reg + ADDR_W'(1);
            end
            OP_RD_SUP:
            begin
                unique case (rd_adj_reg)
                    ADJ_MINUS: xs_reg[rd_k_reg] <= XS_W'(rd_pos_reg) - XS_W'(period);
                    ADJ_PLUS:  xs_reg[rd_k_reg] <= XS_W'(rd_pos_reg) + XS_W'(period);
                    default:   xs_reg[rd_k_reg] <= XS_W'(rd_pos_reg);
                endcase
                ys_reg[rd_k_reg] <= rd_val_reg;
            end
            default:
            begin
            end
        endcase

        // operations issued this cycle
        unique case (cmd.op)
            OP_CAPTURE:  x_reg <= eval_position;
            OP_RD_X0:    below_reg <= '0;
            OP_SET_X0:   x_reg <= x0_reg;
            OP_MOD_PREP:
            begin
                num_reg <= DIV_W'(x_reg) - DIV_W'(x0_reg);
                den_reg <= DIV_W'(period);
            end
            OP_MOD_FIN:  x_reg <= x0_reg + $signed(mod_r[DATA_W-1:0]);
            OP_CELL:
            begin
                if ((x_reg == x0_reg) || (below_reg == '0))
                    cell_reg <= '0;
                else if (below_m1 > last_cell)
                    cell_reg <= last_cell[CELL_W-1:0];
                else
                    cell_reg <= below_m1[CELL_W-1:0];
                sum_reg <= '0;
            end
            OP_W_INIT:
            begin
                w_mag_reg <= WONE;
                w_neg_reg <= 1'b0;
                xi_reg    <= xs_reg[cmd.i];
                yi_reg    <= ys_reg[cmd.i];
            end
            OP_F_PREP:
            begin
                num_reg <= DIV_W'(x_reg) - DIV_W'(xs_reg[cmd.j]);
                den_reg <= DIV_W'(xi_reg) - DIV_W'(xs_reg[cmd.j]);
            end
            OP_F_ZERO:
            begin
                f_mag_reg <= '0;
                f_neg_reg <= 1'b0;
            end
            OP_F_SAT:
            begin
                f_mag_reg <= (div_quo > DVD_W'(WCAP)) ? WCAP : div_quo[DATA_W-1:0];
                f_neg_reg <= num_reg[DIV_W-1] ^ den_reg[DIV_W-1];
            end
            OP_MUL_WF:
            begin
                prod_reg     <= PRD_W'(w_mag_reg) * PRD_W'(f_mag_reg);
                prod_neg_reg <= w_neg_reg ^ f_neg_reg;
            end
            OP_W_UPD:
            begin
                w_mag_reg <= (prod_m > MRD_W'(WCAP)) ? WCAP : prod_m[DATA_W-1:0];
                w_neg_reg <= prod_neg_reg;
            end
            OP_MUL_WY:
            begin
                prod_reg     <= PRD_W'(w_mag_reg) * PRD_W'(yi_mag);
                prod_neg_reg <= w_neg_reg ^ yi_reg[DATA_W-1];
            end
            OP_ACC:
            begin
                if (prod_neg_reg)
                    sum_reg <= sum_reg - $signed(SUM_W'(prod_m));
                else
                    sum_reg <= sum_reg + $signed(SUM_W'(prod_m));
            end
            OP_OUT:
            begin
                if (sum_reg[SUM_W-1:DATA_W-1] == '0 || sum_reg[SUM_W-1:DATA_W-1] == '1)
                    interp_reg <= sum_reg[DATA_W-1:0];
                else if (sum_reg[SUM_W-1])
                    interp_reg <= $signed(WCAP);
                else
                    interp_reg <= $signed(~WCAP);
                mismatch_reg <= (y0_reg != yn_reg);
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    assign stat.need_wrap = (x_reg < x0_reg) || (x_reg > x1_reg);
    // period strictly positive: sign bit clear and not zero
    assign stat.d_pos     = !period[DATA_W] && (period != '0);
    assign stat.den_zero  = (den_reg == '0);
    assign stat.div_busy  = div_busy;
    assign stat.n_eff     = n_eff;

    assign interp_value    = interp_reg;
    assign period_mismatch = mismatch_reg;

endmodule
